/* rtl/twi_pkg.sv */
// Shared constants, types and codes of the trilinear weight interpolator.
`default_nettype none
package twi_pkg;
	localparam int COORD_WIDTH = 32;
	localparam int FRAC_BITS   = 16;
	localparam int VAL_WIDTH   = 32;
	localparam int DW   = COORD_WIDTH + 1;      // coordinate difference
	localparam int MW   = DW + 1;               // signed multiplier operand
	localparam int PW   = 2 * DW;               // product of two differences
	localparam int VW   = 3 * DW;               // product of three differences
	localparam int RW   = VW + 1;               // division remainder
	localparam int WW   = FRAC_BITS + 1;        // weight width
	localparam int SUMW = WW + VAL_WIDTH + 3;   // sum of eight weighted values
	localparam logic [WW-1:0] WEIGHT_ONE = WW'(1) << FRAC_BITS;
	localparam logic [4:0] DIV_LAST = 5'(FRAC_BITS);

	typedef enum logic [4:0] {
		ST_IDLE, ST_SETUP, ST_VOL_A, ST_VOL_B, ST_VOL_C, ST_VSAVE,
		ST_NUM_A, ST_NUM_B, ST_NUM_C, ST_DINIT, ST_DIV, ST_WSAVE,
		ST_DIST_X, ST_DIST_Y, ST_DIST_Z, ST_DCMP, ST_ACC, ST_EMIT
	} twi_state_t;

	typedef enum logic [2:0] {
		OP_NONE, OP_AB, OP_PLO, OP_PHI, OP_DX, OP_DY, OP_DZ, OP_ACC
	} twi_op_t;

	typedef struct packed {
		twi_op_t    op;
		logic       sel_num;
		logic [2:0] k;
		logic       setup;
		logic       vol_save;
		logic       div_init;
		logic       div_step;
		logic       div_first;
		logic       w_save;
		logic       dist_cmp;
	} twi_cmd_t;

	typedef struct packed {
		logic in_box;
		logic den_zero;
	} twi_status_t;
endpackage
`default_nettype wire

/* rtl/twi_if.sv */
// Input and result channel interfaces of the trilinear weight interpolator.
`default_nettype none
interface twi_in_if;
	import twi_pkg::*;
	logic                          valid;
	logic                          ready;
	logic                          req_type;
	logic [2:0]                    vertex_slot;
	logic signed [COORD_WIDTH-1:0] coord_x;
	logic signed [COORD_WIDTH-1:0] coord_y;
	logic signed [COORD_WIDTH-1:0] coord_z;
	logic signed [VAL_WIDTH-1:0]   field_value;
	modport source(output valid, req_type, vertex_slot, coord_x, coord_y, coord_z,
		field_value, input ready);
	modport sink(input valid, req_type, vertex_slot, coord_x, coord_y, coord_z,
		field_value, output ready);
endinterface

interface twi_out_if;
	import twi_pkg::*;
	logic                        valid;
	logic                        ready;
	logic [2:0]                  weight_slot;
	logic [WW-1:0]               weight;
	logic signed [VAL_WIDTH-1:0] interp_value;
	logic                        used_nearest;
	logic                        last;
	modport source(output valid, weight_slot, weight, interp_value, used_nearest, last,
		input ready);
	modport sink(input valid, weight_slot, weight, interp_value, used_nearest, last,
		output ready);
endinterface
`default_nettype wire

/* rtl/twi_ctrl.sv */
// Sequencer of the trilinear weight interpolator: volume, divide, distance scan, emit.
`default_nettype none
module twi_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	input  wire logic                in_req_type,
	output logic                     in_ready,
	output logic                     out_valid,
	input  wire logic                out_ready,
	input  wire twi_pkg::twi_status_t status,
	output twi_pkg::twi_cmd_t        cmd
);
	import twi_pkg::*;

	twi_state_t state_q, state_d;
	logic [2:0] k_q, k_d;
	logic [4:0] cnt_q, cnt_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q     <= '0;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			k_q     <= k_d;
			cnt_q   <= cnt_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		k_d       = k_q;
		cnt_d     = cnt_q;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		cmd       = '0;
		cmd.op    = OP_NONE;
		cmd.k     = k_q;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				k_d = '0;
				if (in_valid && in_req_type)
					state_d = ST_SETUP;
			end
			ST_SETUP: begin
				cmd.setup = 1'b1;
				state_d = status.in_box ? ST_VOL_A : ST_DIST_X;
			end
			ST_VOL_A: begin
				cmd.op = OP_AB;
				state_d = ST_VOL_B;
			end
			ST_VOL_B: begin
				cmd.op = OP_PLO;
				state_d = ST_VOL_C;
			end
			ST_VOL_C: begin
				cmd.op = OP_PHI;
				state_d = ST_VSAVE;
			end
			ST_VSAVE: begin
				cmd.vol_save = 1'b1;
				state_d = status.den_zero ? ST_DIST_X : ST_NUM_A;
			end
			ST_NUM_A: begin
				cmd.op = OP_AB;
				cmd.sel_num = 1'b1;
				state_d = ST_NUM_B;
			end
			ST_NUM_B: begin
				cmd.op = OP_PLO;
				cmd.sel_num = 1'b1;
				state_d = ST_NUM_C;
			end
			ST_NUM_C: begin
				cmd.op = OP_PHI;
				cmd.sel_num = 1'b1;
				state_d = ST_DINIT;
			end
			ST_DINIT: begin
				cmd.div_init = 1'b1;
				cnt_d = '0;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				cmd.div_first = (cnt_q == '0);
				cnt_d = cnt_q + 5'd1;
				if (cnt_q == DIV_LAST) begin
					cnt_d = '0;
					state_d = ST_WSAVE;
				end
			end
			ST_WSAVE: begin
				cmd.w_save = 1'b1;
				k_d = k_q + 3'd1;
				state_d = (k_q == 3'd7) ? ST_ACC : ST_NUM_A;
			end
			ST_DIST_X: begin
				cmd.op = OP_DX;
				state_d = ST_DIST_Y;
			end
			ST_DIST_Y: begin
				cmd.op = OP_DY;
				state_d = ST_DIST_Z;
			end
			ST_DIST_Z: begin
				cmd.op = OP_DZ;
				state_d = ST_DCMP;
			end
			ST_DCMP: begin
				cmd.dist_cmp = 1'b1;
				k_d = k_q + 3'd1;
				state_d = (k_q == 3'd7) ? ST_ACC : ST_DIST_X;
			end
			ST_ACC: begin
				cmd.op = OP_ACC;
				k_d = k_q + 3'd1;
				if (k_q == 3'd7)
					state_d = ST_EMIT;
			end
			ST_EMIT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					k_d = k_q + 3'd1;
					if (k_q == 3'd7)
						state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("input taken while results pending");
	a_back_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && k_q == 3'd7 |=> in_ready)
		else $error("not idle after last item");
	a_div_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= DIV_LAST) else $error("divide counter overrun");
	a_emit_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> k_q == 3'd0) else $error("emit does not start at corner 0");
endmodule
`default_nettype wire

/* rtl/twi_dp.sv */
// Datapath of the trilinear weight interpolator: corner store, multiplier, divider, sum.
`default_nettype none
module twi_dp (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   cfg_we,
	input  wire logic                                   cfg_wdata,
	input  wire logic                                   in_fire,
	input  wire logic                                   req_type,
	input  wire logic [2:0]                             vertex_slot,
	input  wire logic signed [twi_pkg::COORD_WIDTH-1:0] coord_x,
	input  wire logic signed [twi_pkg::COORD_WIDTH-1:0] coord_y,
	input  wire logic signed [twi_pkg::COORD_WIDTH-1:0] coord_z,
	input  wire logic signed [twi_pkg::VAL_WIDTH-1:0]   field_value,
	input  wire twi_pkg::twi_cmd_t                      cmd,
	output twi_pkg::twi_status_t                        status,
	output logic [2:0]                                  weight_slot,
	output logic [twi_pkg::WW-1:0]                      weight,
	output logic signed [twi_pkg::VAL_WIDTH-1:0]        interp_value,
	output logic                                        used_nearest,
	output logic                                        last
);
	import twi_pkg::*;

	localparam int CW = COORD_WIDTH;
	localparam logic signed [SUMW-1:0] VMAX = SUMW'({1'b0, {(VAL_WIDTH-1){1'b1}}});
	localparam logic signed [SUMW-1:0] VMIN = -VMAX - SUMW'(1);

	logic signed [CW-1:0]        cx_q [8];
	logic signed [CW-1:0]        cy_q [8];
	logic signed [CW-1:0]        cz_q [8];
	logic signed [VAL_WIDTH-1:0] val_q [8];
	logic [WW-1:0]               w_q [8];

	logic                 near_only_q, near_q;
	logic signed [CW-1:0] qx_q, qy_q, qz_q;
	logic [DW-1:0]        xlo_q, xhi_q, ylo_q, yhi_q, zlo_q, zhi_q, ex_q, ey_q, ez_q;
	logic [PW-1:0]        p_q;
	logic [VW-1:0]        prod_q, den_q, best_q;
	logic [RW-1:0]        rem_q;
	logic [WW-1:0]        q_q;
	logic [2:0]           bi_q;
	logic signed [SUMW-1:0] sum_q;

	logic [DW-1:0]        fx, fy, fz, a_sel, b_sel, c_sel, dx, dy, dz;
	logic signed [DW-1:0] sdx, sdy, sdz;
	logic signed [MW-1:0] ma, mb;
	logic signed [2*MW-1:0] mp;
	logic [RW-1:0]        rdiv;
	logic                 ge;
	logic [WW-1:0]        wk;
	logic signed [SUMW-1:0] sh;
	logic [2:0]           k;

	function automatic logic [DW-1:0] sdiff(input logic signed [CW-1:0] a,
		input logic signed [CW-1:0] b);
		logic signed [DW-1:0] d;
		d = DW'(a) - DW'(b);
		return d;
	endfunction

	assign k = cmd.k;
	assign status.in_box = !near_only_q &&
		qx_q >= cx_q[0] && qx_q <= cx_q[3] &&
		qy_q >= cy_q[0] && qy_q <= cy_q[1] &&
		qz_q >= cz_q[0] && qz_q <= cz_q[4];
	assign status.den_zero = (prod_q == '0);

	always_comb begin
		fx = k[1] ? xlo_q : xhi_q;
		fy = (k[1] ^ k[0]) ? ylo_q : yhi_q;
		fz = k[2] ? zlo_q : zhi_q;
		a_sel = cmd.sel_num ? fx : ex_q;
		b_sel = cmd.sel_num ? fy : ey_q;
		c_sel = cmd.sel_num ? fz : ez_q;
		sdx = sdiff(qx_q, cx_q[k]);
		sdy = sdiff(qy_q, cy_q[k]);
		sdz = sdiff(qz_q, cz_q[k]);
		dx = sdx[DW-1] ? DW'(-sdx) : sdx;
		dy = sdy[DW-1] ? DW'(-sdy) : sdy;
		dz = sdz[DW-1] ? DW'(-sdz) : sdz;
		wk = near_q ? ((k == bi_q) ? WEIGHT_ONE : '0) : w_q[k];
		case (cmd.op)
			OP_AB: begin
				ma = {1'b0, a_sel};
				mb = {1'b0, b_sel};
			end
			OP_PLO: begin
				ma = {1'b0, p_q[DW-1:0]};
				mb = {1'b0, c_sel};
			end
			OP_PHI: begin
				ma = {1'b0, p_q[PW-1:DW]};
				mb = {1'b0, c_sel};
			end
			OP_DX: begin
				ma = {1'b0, dx};
				mb = {1'b0, dx};
			end
			OP_DY: begin
				ma = {1'b0, dy};
				mb = {1'b0, dy};
			end
			OP_DZ: begin
				ma = {1'b0, dz};
				mb = {1'b0, dz};
			end
			OP_ACC: begin
				ma = {{(MW-WW){1'b0}}, wk};
				mb = MW'(val_q[k]);
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
		mp = ma * mb;
		rdiv = cmd.div_first ? rem_q : {rem_q[RW-2:0], 1'b0};
		ge = rdiv >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			near_only_q <= 1'b0;
		else if (cfg_we)
			near_only_q <= cfg_wdata;
	end

	always_ff @(posedge clk) begin
		if (in_fire && !req_type) begin
			cx_q[vertex_slot]  <= coord_x;
			cy_q[vertex_slot]  <= coord_y;
			cz_q[vertex_slot]  <= coord_z;
			val_q[vertex_slot] <= field_value;
		end
		if (in_fire && req_type) begin
			qx_q <= coord_x;
			qy_q <= coord_y;
			qz_q <= coord_z;
		end
		if (cmd.setup) begin
			near_q <= !status.in_box;
			sum_q  <= '0;
			xlo_q  <= sdiff(qx_q, cx_q[0]);
			xhi_q  <= sdiff(cx_q[3], qx_q);
			ylo_q  <= sdiff(qy_q, cy_q[0]);
			yhi_q  <= sdiff(cy_q[1], qy_q);
			zlo_q  <= sdiff(qz_q, cz_q[0]);
			zhi_q  <= sdiff(cz_q[4], qz_q);
			ex_q   <= sdiff(cx_q[3], cx_q[0]);
			ey_q   <= sdiff(cy_q[1], cy_q[0]);
			ez_q   <= sdiff(cz_q[4], cz_q[0]);
		end
		case (cmd.op)
			OP_AB:  p_q <= mp[PW-1:0];
			OP_PLO, OP_DX: prod_q <= {{(VW-PW){1'b0}}, mp[PW-1:0]};
			OP_PHI: prod_q <= prod_q + {mp[PW-1:0], {DW{1'b0}}};
			OP_DY, OP_DZ: prod_q <= prod_q + {{(VW-PW){1'b0}}, mp[PW-1:0]};
			OP_ACC: sum_q <= sum_q + mp[SUMW-1:0];
			default: ;
		endcase
		if (cmd.vol_save) begin
			den_q <= prod_q;
			// a flat cell falls back to nearest corner
			if (status.den_zero)
				near_q <= 1'b1;
		end
		if (cmd.div_init) begin
			rem_q <= {1'b0, prod_q};
			q_q   <= '0;
		end
		if (cmd.div_step) begin
			rem_q <= ge ? rdiv - {1'b0, den_q} : rdiv;
			q_q   <= {q_q[WW-2:0], ge};
		end
		if (cmd.w_save)
			w_q[k] <= q_q;
		// later corner wins a tie
		if (cmd.dist_cmp && (k == 3'd0 || prod_q <= best_q)) begin
			best_q <= prod_q;
			bi_q   <= k;
		end
	end

	always_comb begin
		sh = sum_q >>> FRAC_BITS;
		weight_slot  = k;
		weight       = wk;
		used_nearest = near_q;
		last         = (k == 3'd7);
		if (!last)
			interp_value = '0;
		else if (sh > VMAX)
			interp_value = VMAX[VAL_WIDTH-1:0];
		else if (sh < VMIN)
			interp_value = VMIN[VAL_WIDTH-1:0];
		else
			interp_value = sh[VAL_WIDTH-1:0];
	end
endmodule
`default_nettype wire

/* rtl/trilinear_weight_interpolator_unit.sv */
// Top level of the trilinear weight interpolator: controller plus datapath.
// Usage: the in_ch channel takes two kinds of item. A load item (req_type 0)
// writes one of eight corner vertices with its field value and gives no
// result; it is taken whenever the block is idle. A query item (req_type 1) yields eight
// result items on out_ch, one per corner in corner order, the last one
// carrying the interpolated value and last set.
// Steps per query: a point outside the box, or nearest mode, runs a setup
// step, eight distance steps on the shared multiplier, then one accumulate
// step per corner before its first result is offered; a flat cell runs
// the volume steps before the distance steps.
// A point inside the box runs setup, the volume steps, and for each corner
// a product, a divider load, a 17-step restoring divide and a save, then
// one accumulate step per corner.
// Results leave at one per cycle while out_ch.ready is high; a stall holds
// the current result and the block takes no new item until the eighth
// result is accepted. One query is in flight at a time.
// Reset clears the controller and nearest_only; corner entries must be
// loaded before a query reads them. cfg_we writes nearest_only.
`default_nettype none
module trilinear_weight_interpolator_unit (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cfg_we,
	input  wire logic cfg_wdata,
	twi_in_if.sink    in_ch,
	twi_out_if.source out_ch
);
	import twi_pkg::*;

	twi_cmd_t    cmd;
	twi_status_t status;
	logic        in_fire;

	assign in_fire = in_ch.valid && in_ch.ready;

	twi_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_ch.valid),
		.in_req_type(in_ch.req_type),
		.in_ready   (in_ch.ready),
		.out_valid  (out_ch.valid),
		.out_ready  (out_ch.ready),
		.status     (status),
		.cmd        (cmd)
	);

	twi_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.in_fire     (in_fire),
		.req_type    (in_ch.req_type),
		.vertex_slot (in_ch.vertex_slot),
		.coord_x     (in_ch.coord_x),
		.coord_y     (in_ch.coord_y),
		.coord_z     (in_ch.coord_z),
		.field_value (in_ch.field_value),
		.cmd         (cmd),
		.status      (status),
		.weight_slot (out_ch.weight_slot),
		.weight      (out_ch.weight),
		.interp_value(out_ch.interp_value),
		.used_nearest(out_ch.used_nearest),
		.last        (out_ch.last)
	);
endmodule
`default_nettype wire
